// ===== src/tfb_pkg.sv =====
// Shared types, codes and per-kind frame layout for the telemetry frame builder.
package tfb_pkg;

  typedef enum logic [2:0] {
    KIND_ANGLE   = 3'd0,
    KIND_MAGNET  = 3'd1,
    KIND_INERTIAL = 3'd2,
    KIND_PULSE   = 3'd3,
    KIND_GAINS   = 3'd4,
    KIND_QUAT    = 3'd5
  } kind_t;

  localparam int unsigned NUM_VALUES = 6;
  localparam int unsigned CFG_INDEX_W = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_HEAD_BYTE = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TARGET_ADDRESS = 8'd1;

  localparam logic [7:0] HEAD_RESET = 8'hAA;
  localparam logic [7:0] TARGET_RESET = 8'hFF;

  localparam logic [7:0] ID_ANGLE = 8'h03;
  localparam logic [7:0] ID_MAGNET = 8'h02;
  localparam logic [7:0] ID_INERTIAL = 8'hF1;
  localparam logic [7:0] ID_PULSE = 8'h20;
  localparam logic [7:0] ID_GAINS = 8'hF2;
  localparam logic [7:0] ID_QUAT = 8'h04;

  localparam logic [7:0] STATUS_BYTE = 8'h01;
  localparam logic [7:0] PAD_BYTE = 8'h00;

  // One classified frame request as it travels from front to back.
  typedef struct packed {
    kind_t                         kind;
    logic [7:0]                    head;
    logic [7:0]                    target;
    logic [NUM_VALUES-1:0][15:0]   values;
  } cmd_t;

  function automatic logic kind_valid(input logic [2:0] code);
    kind_valid = (code <= KIND_QUAT);
  endfunction

  function automatic logic [7:0] kind_id(input kind_t kind);
    case (kind)
      KIND_ANGLE:    kind_id = ID_ANGLE;
      KIND_MAGNET:   kind_id = ID_MAGNET;
      KIND_INERTIAL: kind_id = ID_INERTIAL;
      KIND_PULSE:    kind_id = ID_PULSE;
      KIND_GAINS:    kind_id = ID_GAINS;
      KIND_QUAT:     kind_id = ID_QUAT;
      default:       kind_id = PAD_BYTE;
    endcase
  endfunction

  // Payload length byte: value bytes plus status, padding or zero fill.
  function automatic logic [3:0] kind_len(input kind_t kind);
    case (kind)
      KIND_ANGLE:    kind_len = 4'd7;
      KIND_MAGNET:   kind_len = 4'd14;
      KIND_INERTIAL: kind_len = 4'd13;
      KIND_PULSE:    kind_len = 4'd8;
      KIND_GAINS:    kind_len = 4'd6;
      KIND_QUAT:     kind_len = 4'd9;
      default:       kind_len = 4'd0;
    endcase
  endfunction

  function automatic logic [3:0] kind_value_bytes(input kind_t kind);
    case (kind)
      KIND_ANGLE:    kind_value_bytes = 4'd6;
      KIND_MAGNET:   kind_value_bytes = 4'd6;
      KIND_INERTIAL: kind_value_bytes = 4'd12;
      KIND_PULSE:    kind_value_bytes = 4'd8;
      KIND_GAINS:    kind_value_bytes = 4'd6;
      KIND_QUAT:     kind_value_bytes = 4'd8;
      default:       kind_value_bytes = 4'd0;
    endcase
  endfunction

  // Byte that follows the values: a status flag for angle and inertial, else zero.
  function automatic logic [7:0] kind_fill(input kind_t kind);
    case (kind)
      KIND_ANGLE:    kind_fill = STATUS_BYTE;
      KIND_INERTIAL: kind_fill = STATUS_BYTE;
      default:       kind_fill = PAD_BYTE;
    endcase
  endfunction

endpackage

// ===== src/tfb_front.sv =====
// Front end: configuration registers, request intake and kind classification.
module tfb_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tfb_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [7:0]                        cfg_data,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  logic [2:0]                        opcode,
  input  logic [tfb_pkg::NUM_VALUES-1:0][15:0] values,
  output logic                              push_valid,
  input  logic                              push_ready,
  output tfb_pkg::cmd_t                     push_cmd
);

  logic [7:0] head;
  logic [7:0] target;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= tfb_pkg::HEAD_RESET;
      target <= tfb_pkg::TARGET_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        tfb_pkg::REG_HEAD_BYTE:      head <= cfg_data;
        tfb_pkg::REG_TARGET_ADDRESS: target <= cfg_data;
        default: ;
      endcase
    end
  end

  // Undefined kinds are taken and dropped without reaching the queue.
  assign item_ready = push_ready;
  assign push_valid = item_valid && tfb_pkg::kind_valid(opcode);

  always_comb begin
    push_cmd.kind   = tfb_pkg::kind_t'(opcode);
    push_cmd.head   = head;
    push_cmd.target = target;
    push_cmd.values = values;
  end

endmodule

// ===== src/tfb_queue.sv =====
// Short FIFO of classified frame requests between front and back.
module tfb_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  tfb_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output tfb_pkg::cmd_t pop_cmd
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

  tfb_pkg::cmd_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic do_push;
  logic do_pop;

  assign push_ready = (count != FULL_COUNT);
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/tfb_back.sv =====
// Back end: byte serializer with running dual-sum checksum and output register.
module tfb_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  tfb_pkg::cmd_t pop_cmd,
  output logic          byte_valid,
  input  logic          byte_ready,
  output logic [7:0]    frame_byte,
  output logic          last_byte
);

  tfb_pkg::cmd_t cmd;
  logic          busy;
  logic [4:0]    idx;
  logic [7:0]    s1;
  logic [7:0]    s2;

  logic [3:0]    len;
  logic [4:0]    total;
  logic [4:0]    pos;
  logic [15:0]   word;
  logic [7:0]    payload;
  logic [7:0]    cur;
  logic          is_sum;
  logic          is_last;
  logic          advance;
  logic          load;

  assign len     = tfb_pkg::kind_len(cmd.kind);
  assign total   = 5'(len) + 5'd6;
  assign pos     = idx - 5'd4;
  assign is_last = (idx == total - 5'd1);
  assign is_sum  = (idx == total - 5'd2) || is_last;
  assign advance = busy && (!byte_valid || byte_ready);
  assign pop_ready = !busy;
  assign load    = pop_valid && pop_ready;

  always_comb begin
    case (pos[3:1])
      3'd0:    word = cmd.values[0];
      3'd1:    word = cmd.values[1];
      3'd2:    word = cmd.values[2];
      3'd3:    word = cmd.values[3];
      3'd4:    word = cmd.values[4];
      3'd5:    word = cmd.values[5];
      default: word = '0;
    endcase
    if (pos[3:0] < tfb_pkg::kind_value_bytes(cmd.kind)) begin
      payload = pos[0] ? word[15:8] : word[7:0];
    end else begin
      payload = tfb_pkg::kind_fill(cmd.kind);
    end

    case (idx)
      5'd0:    cur = cmd.head;
      5'd1:    cur = cmd.target;
      5'd2:    cur = tfb_pkg::kind_id(cmd.kind);
      5'd3:    cur = {4'd0, len};
      default: begin
        if (is_last) begin
          cur = s2;
        end else if (is_sum) begin
          cur = s1;
        end else begin
          cur = payload;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cmd <= pop_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      idx        <= '0;
      byte_valid <= 1'b0;
    end else begin
      if (load) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (advance) begin
        if (is_last) begin
          busy <= 1'b0;
        end else begin
          idx <= idx + 1'b1;
        end
      end
      if (advance) begin
        byte_valid <= 1'b1;
      end else if (byte_ready) begin
        byte_valid <= 1'b0;
      end
    end
  end

  // Checksums accumulate over every byte ahead of them; hold them over the sum bytes.
  always_ff @(posedge clk) begin
    if (load) begin
      s1 <= '0;
      s2 <= '0;
    end else if (advance && !is_sum) begin
      s1 <= s1 + cur;
      s2 <= s2 + s1 + cur;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      frame_byte <= cur;
      last_byte  <= is_last;
    end
  end

endmodule

// ===== src/telemetry_frame_builder.sv =====
// Telemetry frame builder: one frame request in, one byte-serial frame out, ending
// in a mod-256 byte sum and a mod-256 sum of running sums. Each frame of 12 to 20
// bytes, set by the kind, is loaded from the queue into the serializer, then sent
// one byte per cycle, unless byte_ready stalls, from the output register, the
// bottleneck. Requests with an undefined kind are taken and dropped. The request
// queue holds QUEUE_DEPTH frames, so intake runs ahead of transmission.
module telemetry_frame_builder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tfb_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [7:0]                       cfg_data,
  input  logic                             item_valid,
  output logic                             item_ready,
  input  logic [2:0]                       opcode,
  input  logic signed [15:0]               value_a,
  input  logic signed [15:0]               value_b,
  input  logic signed [15:0]               value_c,
  input  logic signed [15:0]               value_d,
  input  logic signed [15:0]               value_e,
  input  logic signed [15:0]               value_f,
  output logic                             byte_valid,
  input  logic                             byte_ready,
  output logic [7:0]                       frame_byte,
  output logic                             last_byte
);

  logic [tfb_pkg::NUM_VALUES-1:0][15:0] values;
  logic          push_valid;
  logic          push_ready;
  tfb_pkg::cmd_t push_cmd;
  logic          pop_valid;
  logic          pop_ready;
  tfb_pkg::cmd_t pop_cmd;

  assign values = {value_f, value_e, value_d, value_c, value_b, value_a};

  tfb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .opcode     (opcode),
    .values     (values),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  tfb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  tfb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .frame_byte (frame_byte),
    .last_byte  (last_byte)
  );

endmodule

// ===== src/tfb_checker.sv =====
// Port-level checks for the telemetry frame builder, bound to the top level.
module tfb_checker (
  input logic       clk,
  input logic       rst,
  input logic       cfg_ready,
  input logic       byte_valid,
  input logic       byte_ready,
  input logic [7:0] frame_byte,
  input logic       last_byte
);

  logic       byte_fire;
  logic [4:0] count;

  assign byte_fire = byte_valid && byte_ready;

  // Track bytes accepted so far within the current frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (byte_fire) begin
      count <= last_byte ? 5'd0 : count + 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    byte_valid && !byte_ready |=> byte_valid && $stable(frame_byte) && $stable(last_byte))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !byte_valid)
    else $error("result valid right after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("configuration port not ready");

  a_frame_len: assert property (@(posedge clk) disable iff (rst)
    byte_fire && last_byte |->
      count == 5'd11 || count == 5'd12 || count == 5'd13 ||
      count == 5'd14 || count == 5'd18 || count == 5'd19)
    else $error("frame closed at an illegal length");

  a_frame_max: assert property (@(posedge clk) disable iff (rst)
    byte_fire && !last_byte |-> count < 5'd19)
    else $error("frame ran past its longest length");

endmodule

bind telemetry_frame_builder tfb_checker u_tfb_checker (
  .clk        (clk),
  .rst        (rst),
  .cfg_ready  (cfg_ready),
  .byte_valid (byte_valid),
  .byte_ready (byte_ready),
  .frame_byte (frame_byte),
  .last_byte  (last_byte)
);
